FILE: design/sensor_bus_packet_framer_macros.svh
// Assertion macros for the sensor bus packet framer.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef SENSOR_BUS_PACKET_FRAMER_MACROS_SVH
`define SENSOR_BUS_PACKET_FRAMER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SBPF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sensor bus packet framer: assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SBPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sensor bus packet framer: assertion failed");

`endif

FILE: design/sbpf_pkg.sv
// Shared constants, types and the folded checksum step of the packet framer.
// No dependencies.
`default_nettype none

package sbpf_pkg;

    localparam logic [7:0] ESC_MARK   = 8'h7D;
    localparam logic [7:0] FLAG_MARK  = 8'h7E;
    localparam logic [7:0] ESC_FLIP   = 8'h20;
    localparam logic [7:0] CHECK_BASE = 8'hFF;

    // Header, two id bytes and four payload bytes, in send order.
    localparam int RAW_BYTES   = 7;
    localparam int FRAME_BYTES = RAW_BYTES + 1;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    localparam logic [IDX_W-1:0] IDX_HEADER = '0;
    localparam logic [IDX_W-1:0] IDX_CHECK  = IDX_W'(FRAME_BYTES - 1);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    // Register index is the word address: paddr[2].
    localparam logic REG_FRAME_HEADER = 1'b0;

    localparam logic [7:0] FRAME_HEADER_RESET = 8'h10;

    typedef logic [RAW_BYTES-1:0][7:0] raw_frame_t;

    // Add one byte and fold the carry back into the low eight bits.
    function automatic logic [7:0] sum_add(input logic [7:0] sum, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, sum} + {1'b0, b};
        return s[7:0] + {7'b0, s[8]};
    endfunction

endpackage

`default_nettype wire

FILE: design/sbpf_check.sv
// Check byte of one frame: 0xFF minus the folded sum over the raw bytes.
// Depends on sbpf_pkg.
`default_nettype none

module sbpf_check
    import sbpf_pkg::*;
(
    input  wire raw_frame_t raw,
    output logic [7:0]      check_byte
);

    logic [7:0] sum;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < RAW_BYTES; i++)
        begin
            sum = sum_add(sum, raw[i]);
        end
        check_byte = CHECK_BASE - sum;
    end

endmodule

`default_nettype wire

FILE: design/sensor_bus_packet_framer.sv
// Top level of the sensor bus packet framer: frame register, byte serializer
// with escaping, header register on the APB port. Depends on sbpf_pkg,
// sbpf_check and sensor_bus_packet_framer_macros.svh.
//
//   Channel   Direction  Handshake                    Payload
//   command   in         start & !busy                data_id, payload
//   result    out        strobe (one cycle, no stall) out_byte, last
//   config    in         APB write, pready always 1   frame_header at 0x0
//
// A frame is 8 to 15 bytes; the serializer sends one byte a cycle, an
// escaped byte as an escape pair. The first byte passes the serializer
// state, then the output registers. busy drops in the cycle the final
// byte is formed, so the next command follows with no gap. Reset clears
// the serializer and sets the header to 0x10. The receiver cannot stall.
`default_nettype none

`include "sensor_bus_packet_framer_macros.svh"

module sensor_bus_packet_framer
    import sbpf_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    // command channel
    input  wire                start,
    output logic               busy,
    input  wire  [15:0]        data_id,
    input  wire  [31:0]        payload,
    // result channel
    output logic               strobe,
    output logic [7:0]         out_byte,
    output logic               last,
    // configuration port
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [PADDR_W-1:0] paddr,
    input  wire  [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [7:0]       frame_header_reg;
    raw_frame_t       frame_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             esc_reg, esc_next;
    logic             active_reg;
    logic             strobe_reg;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             last_reg, last_next;

    logic             accept;
    logic             cfg_write;
    logic [7:0]       check_byte;
    logic [7:0]       cur_byte;
    logic             needs_esc;
    logic             final_cyc;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        if (paddr[2] == REG_FRAME_HEADER)
            prdata = {{(PDATA_W-8){1'b0}}, frame_header_reg};
        else
            prdata = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_header_reg <= FRAME_HEADER_RESET;
        else if (cfg_write && paddr[2] == REG_FRAME_HEADER)
            frame_header_reg <= pwdata[7:0];
    end

    // ---------------- frame register ----------------
    assign accept = start && !busy;

    always_ff @(posedge clk)
    begin
        if (accept)
            frame_reg <= {payload, data_id, frame_header_reg};
    end

    sbpf_check u_check (
        .raw        (frame_reg),
        .check_byte (check_byte)
    );

    // ---------------- serializer ----------------
    always_comb
    begin
        if (idx_reg == IDX_CHECK)
            cur_byte = check_byte;
        else
            cur_byte = frame_reg[idx_reg];
    end

    // The header goes out raw even when it matches an escape value.
    assign needs_esc = (idx_reg != IDX_HEADER) &&
                       (cur_byte == ESC_MARK || cur_byte == FLAG_MARK);

    always_comb
    begin
        if (needs_esc && !esc_reg)
        begin
            out_byte_next = ESC_MARK;
            last_next     = 1'b0;
            esc_next      = 1'b1;
            idx_next      = idx_reg;
        end
        else
        begin
            out_byte_next = esc_reg ? (cur_byte ^ ESC_FLIP) : cur_byte;
            last_next     = (idx_reg == IDX_CHECK);
            esc_next      = 1'b0;
            idx_next      = idx_reg + 1'b1;
        end
    end

    assign final_cyc = active_reg && last_next;
    assign busy      = active_reg && !final_cyc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            esc_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= active_reg;
            if (accept)
            begin
                active_reg <= 1'b1;
                idx_reg    <= IDX_HEADER;
                esc_reg    <= 1'b0;
            end
            else if (active_reg)
            begin
                active_reg <= !final_cyc;
                idx_reg    <= idx_next;
                esc_reg    <= esc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next && active_reg;
    end

    assign strobe   = strobe_reg;
    assign out_byte = out_byte_reg;
    assign last     = last_reg && strobe_reg;

    // ---------------- assertions ----------------
    // The header byte leads every frame; after the command transfer it passes the
    // serializer state, then the output registers, before it is on the result ports.
    `SBPF_ASSERT_NEXT(a_header_first, $past(accept), strobe && !last && out_byte == frame_reg[IDX_HEADER])
    // While the second half of an escape pair is pending, the escape mark is on the line.
    `SBPF_ASSERT_NOW(a_escape_pair, esc_reg, strobe && out_byte == ESC_MARK && !last)
    // No new command is taken while a frame still has bytes to send after this cycle.
    `SBPF_ASSERT_NOW(a_no_overlap, active_reg && !last_next, busy && !accept)

endmodule

`default_nettype wire
